// ===== hdl/address_to_symbol_lookup_macros.svh =====
// assertion macros used by the address to symbol lookup top level
`ifndef ADDRESS_TO_SYMBOL_LOOKUP_MACROS_SVH
`define ADDRESS_TO_SYMBOL_LOOKUP_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define ATSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("atsl same-cycle check failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define ATSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("atsl next-cycle check failed");

`endif

// ===== hdl/atsl_pkg.sv =====
// shared types, codes and field layout of the address to symbol lookup
package atsl_pkg;

	localparam int MAX_SYMBOLS_DEF = 1024;

	// input field widths
	localparam int INDEX_W   = 10;
	localparam int ADDR_W    = 64;
	localparam int TYPE_W    = 4;
	localparam int SECTION_W = 16;
	localparam int NAME_W    = 32;
	localparam int COUNT_W   = 11;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// slave tdata layout, lowest bit first
	localparam int IN_INDEX_LO   = 0;
	localparam int IN_START_LO   = IN_INDEX_LO + INDEX_W;
	localparam int IN_LENGTH_LO  = IN_START_LO + ADDR_W;
	localparam int IN_TYPE_LO    = IN_LENGTH_LO + ADDR_W;
	localparam int IN_SECTION_LO = IN_TYPE_LO + TYPE_W;
	localparam int IN_NAME_LO    = IN_SECTION_LO + SECTION_W;
	localparam int IN_QUERY_LO   = IN_NAME_LO + NAME_W;
	localparam int IN_USED_W     = IN_QUERY_LO + ADDR_W;
	localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

	// master tdata layout, lowest bit first
	localparam int OUT_NAME_LO   = 0;
	localparam int OUT_OFFSET_LO = OUT_NAME_LO + NAME_W;
	localparam int OUT_USED_W    = OUT_OFFSET_LO + ADDR_W;
	localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

	// table word layout
	localparam int ENT_START_LO  = 0;
	localparam int ENT_LENGTH_LO = ENT_START_LO + ADDR_W;
	localparam int ENT_NAME_LO   = ENT_LENGTH_LO + ADDR_W;
	localparam int ENT_ELIG_BIT  = ENT_NAME_LO + NAME_W;
	localparam int ENTRY_W       = ENT_ELIG_BIT + 1;

	// operation codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	// symbol codes
	localparam logic [TYPE_W-1:0]    TYPE_FUNC     = 4'd2;
	localparam logic [SECTION_W-1:0] SECTION_UNDEF = 16'd0;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_TABLE_READY = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SYMBOL_CNT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NAME_BOUND  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic query_ld;
		logic rd_en;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic op_resolve;
		logic scan_skip;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

// ===== hdl/atsl_ram.sv =====
// generic single write port, single read port ram with registered read
module atsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/atsl_ctrl.sv =====
// controller state machine for loads and table scans
module atsl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	input  atsl_pkg::stat_t stat,
	output atsl_pkg::cmd_t  cmd
);

	atsl_pkg::state_t state_q;
	atsl_pkg::state_t state_d;
	logic             accept;

	assign s_ready = (state_q == atsl_pkg::ST_IDLE);
	assign accept  = s_valid && s_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			atsl_pkg::ST_IDLE: begin
				if (accept) begin
					if (stat.op_resolve) begin
						cmd.query_ld = 1'b1;
						state_d = stat.scan_skip ? atsl_pkg::ST_FINISH : atsl_pkg::ST_SCAN;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			atsl_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (stat.scan_last) begin
					state_d = atsl_pkg::ST_DRAIN;
				end
			end
			// last read word is compared in this cycle
			atsl_pkg::ST_DRAIN: begin
				state_d = atsl_pkg::ST_FINISH;
			end
			atsl_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = atsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = atsl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/atsl_datapath.sv =====
// datapath: config registers, symbol table, scan compare and result register
module atsl_datapath #(
	parameter int MAX_SYMBOLS = atsl_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [atsl_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [atsl_pkg::CFG_W-1:0]       cfg_data,
	input  logic [atsl_pkg::IN_DATA_W-1:0]   s_data,
	input  logic                             s_user,
	output logic                             m_valid,
	input  logic                             m_ready,
	output logic [atsl_pkg::OUT_DATA_W-1:0]  m_data,
	output logic                             m_user,
	input  atsl_pkg::cmd_t                   cmd,
	output atsl_pkg::stat_t                  stat
);

	localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int AD = atsl_pkg::ADDR_W;
	localparam int NW = atsl_pkg::NAME_W;

	// config registers
	logic                          table_ready_q;
	logic [atsl_pkg::COUNT_W-1:0]  symbol_count_q;
	logic [NW-1:0]                 name_bound_q;

	// input fields
	logic [atsl_pkg::INDEX_W-1:0]   in_index;
	logic [AD-1:0]                  in_start;
	logic [AD-1:0]                  in_length;
	logic [atsl_pkg::TYPE_W-1:0]    in_type;
	logic [atsl_pkg::SECTION_W-1:0] in_section;
	logic [NW-1:0]                  in_name;
	logic [AD-1:0]                  in_query;
	logic                           in_elig;
	logic                           in_range;

	// table ports
	logic [AW-1:0]                  idx_q;
	logic [atsl_pkg::ENTRY_W-1:0]   wr_word;
	logic [atsl_pkg::ENTRY_W-1:0]   rd_word;

	// scan
	logic [31:0]   limit;
	logic [AD-1:0] query_q;
	logic          eval_s1;
	logic [AD-1:0] rd_start;
	logic [AD-1:0] rd_length;
	logic [NW-1:0] rd_name;
	logic          rd_elig;
	logic [AD-1:0] diff;
	logic          cand;
	logic          have_q;
	logic [AD-1:0] best_start_q;
	logic [NW-1:0] best_name_q;
	logic [AD-1:0] best_off_q;
	logic          found;

	// result register
	logic                            m_valid_q;
	logic                            m_user_q;
	logic [atsl_pkg::OUT_DATA_W-1:0] m_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_ready_q  <= 1'b0;
			symbol_count_q <= '0;
			name_bound_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				atsl_pkg::REG_TABLE_READY: table_ready_q  <= cfg_data[0];
				atsl_pkg::REG_SYMBOL_CNT:  symbol_count_q <= cfg_data[atsl_pkg::COUNT_W-1:0];
				atsl_pkg::REG_NAME_BOUND:  name_bound_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_index   = s_data[atsl_pkg::IN_INDEX_LO +: atsl_pkg::INDEX_W];
	assign in_start   = s_data[atsl_pkg::IN_START_LO +: AD];
	assign in_length  = s_data[atsl_pkg::IN_LENGTH_LO +: AD];
	assign in_type    = s_data[atsl_pkg::IN_TYPE_LO +: atsl_pkg::TYPE_W];
	assign in_section = s_data[atsl_pkg::IN_SECTION_LO +: atsl_pkg::SECTION_W];
	assign in_name    = s_data[atsl_pkg::IN_NAME_LO +: NW];
	assign in_query   = s_data[atsl_pkg::IN_QUERY_LO +: AD];

	assign in_elig  = (in_type == atsl_pkg::TYPE_FUNC) &&
		(in_section != atsl_pkg::SECTION_UNDEF) && (in_start != '0);
	assign in_range = (32'(in_index) < 32'(MAX_SYMBOLS));
	assign wr_word  = {in_elig, in_name, in_length, in_start};

	atsl_ram #(
		.WIDTH (atsl_pkg::ENTRY_W),
		.DEPTH (MAX_SYMBOLS)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.load_wr && in_range),
		.wr_addr (AW'(in_index)),
		.wr_data (wr_word),
		.rd_en   (cmd.rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_word)
	);

	// entries scanned: symbol_count clipped to the table depth
	assign limit = (32'(symbol_count_q) > 32'(MAX_SYMBOLS)) ?
		32'(MAX_SYMBOLS) : 32'(symbol_count_q);

	assign stat.op_resolve = (s_user == atsl_pkg::OP_RESOLVE);
	assign stat.scan_skip  = !table_ready_q || (symbol_count_q == '0);
	assign stat.scan_last  = ((32'(idx_q) + 32'd1) == limit);
	assign stat.out_free   = !m_valid_q || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			eval_s1 <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			eval_s1 <= cmd.rd_en;
			if (cmd.query_ld) begin
				idx_q  <= '0;
				have_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					idx_q <= idx_q + AW'(1);
				end
				if (eval_s1 && cand) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	assign rd_start  = rd_word[atsl_pkg::ENT_START_LO +: AD];
	assign rd_length = rd_word[atsl_pkg::ENT_LENGTH_LO +: AD];
	assign rd_name   = rd_word[atsl_pkg::ENT_NAME_LO +: NW];
	assign rd_elig   = rd_word[atsl_pkg::ENT_ELIG_BIT];

	// start not above the address keeps the difference from wrapping
	assign diff = query_q - rd_start;
	assign cand = rd_elig && (rd_start <= query_q) &&
		((rd_length == '0) || (diff < rd_length)) &&
		(!have_q || (rd_start > best_start_q));

	always_ff @(posedge clk) begin
		if (cmd.query_ld) begin
			query_q <= in_query;
		end
		if (eval_s1 && cand && !cmd.query_ld) begin
			best_start_q <= rd_start;
			best_name_q  <= rd_name;
			best_off_q   <= diff;
		end
	end

	assign found = have_q && (best_name_q < name_bound_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			m_user_q <= found;
			m_data_q <= found ?
				atsl_pkg::OUT_DATA_W'({best_off_q, best_name_q}) : '0;
		end
	end

	assign m_valid = m_valid_q;
	assign m_data  = m_data_q;
	assign m_user  = m_user_q;

endmodule

// ===== hdl/address_to_symbol_lookup.sv =====
// top level of the address to symbol lookup
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata entry and query, tuser operation
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata name and offset, tuser found
//  cfg       in         cfg_valid/cfg_ready            cfg_index, cfg_data
//
// a load writes the table on acceptance, and loads may follow back to back
// a resolve holds s_axis_tready low through its scan, last compare and result load:
// one read per cycle over the single read port for min(symbol_count, MAX_SYMBOLS) entries
// with table_ready low or symbol_count zero a resolve skips the scan and goes to ST_FINISH
// reset clears control and config only; table entries read undefined until loaded
// a result waits in the output register; a second resolve stalls only in ST_FINISH until it is free
`include "address_to_symbol_lookup_macros.svh"

module address_to_symbol_lookup #(
	parameter int MAX_SYMBOLS = atsl_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [atsl_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [atsl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// entry_index, entry_start, entry_length, entry_type, entry_section, entry_name,
	// query_address, zero fill
	input  logic [atsl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// operation
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// name_offset, offset_in_function
	output logic [atsl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// found
	output logic                             m_axis_tuser
);

	atsl_pkg::cmd_t  cmd;
	atsl_pkg::stat_t stat;

	atsl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	atsl_datapath #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_data    (s_axis_tdata),
		.s_user    (s_axis_tuser),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata),
		.m_user    (m_axis_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

	// a resolve transaction makes the input side busy
	`ATSL_ASSERT_NEXT(a_resolve_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == atsl_pkg::OP_RESOLVE), !s_axis_tready)
	// a miss carries zero name and offset
	`ATSL_ASSERT_SAME(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
	// a result never overwrites one still waiting
	`ATSL_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_ld, !m_axis_tvalid || m_axis_tready)

endmodule
